// File: rtl/core/toolpath_move_statistics_macros.svh
// Assertion macros shared by the toolpath move statistics RTL.
`ifndef TOOLPATH_MOVE_STATISTICS_MACROS_SVH
`define TOOLPATH_MOVE_STATISTICS_MACROS_SVH

`ifndef SYNTH
`define TMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TMS_ASSERT_IMP(lbl, ante, cons, msg)
`define TMS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/tms_pkg.sv
// Constants and types for the toolpath move statistics block.
package tms_pkg;

  localparam int POS_W   = 32;
  localparam int FEED_W  = 24;
  localparam int TOT_W   = 48;
  localparam int SUM_W   = 66;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int SUB_W   = REM_W + 2;
  localparam int TIME_SH = 14;
  localparam int CNT_W   = 6;

  localparam int ROOT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = TOT_W;
  localparam int AXES       = 3;

  localparam int IN_DATA_W  = 120;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 208;
  localparam int OUT_USER_W = 1;

  localparam logic [TOT_W-1:0] FULL_SCALE = {TOT_W{1'b1}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  localparam logic [FEED_W-1:0] RAPID_FEED_RST   = 24'd80000;
  localparam logic [FEED_W-1:0] DEFAULT_FEED_RST = 24'd16000;
  localparam logic [FEED_W-1:0] FEED_FLOOR_RST   = 24'd16;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_RAPID_FEED   = 2'd0;
  localparam reg_index_t REG_DEFAULT_FEED = 2'd1;
  localparam reg_index_t REG_FEED_FLOOR   = 2'd2;

  typedef logic [1:0] move_kind_t;
  localparam move_kind_t KIND_RAPID   = 2'd0;
  localparam move_kind_t KIND_RETRACT = 2'd1;

endpackage

// File: rtl/core/toolpath_move_statistics.sv
// Top level of the toolpath move statistics block: sequencer and shared datapath.
//
// One move word yields one result word. A path-start move goes from S_IDLE
// straight to S_DONE. Any other move passes S_SQUARE, S_ROOT, S_LEN, S_DIV and
// S_TIME to S_DONE: it squares and sums the axis deltas on one 32x32 multiplier,
// takes the bit-pair square root and runs the restoring divide that turns length
// into time. The root and the divide both run on one shared subtractor, one bit per
// cycle, and that subtractor sets the rate. The result sits in an output
// register, so the next move can be taken while a result still waits.
`include "toolpath_move_statistics_macros.svh"

module toolpath_move_statistics (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata, lowest bit up: pos_x, pos_y, pos_z, feedrate.
  input  logic [tms_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser, lowest bit up: starts_path, move_kind.
  input  logic [tms_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata, lowest bit up: cutting_length, rapid_length, estimated_time,
  // lowest_z, highest_z.
  output logic [tms_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser, lowest bit up: saturated.
  output logic [tms_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  tms_pkg::reg_index_t           cfg_index,
  input  logic [tms_pkg::FEED_W-1:0]     cfg_data
);
  import tms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ROOT,
    S_LEN,
    S_DIV,
    S_TIME,
    S_DONE
  } state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [FEED_W-1:0]        rapid_feed_r;
  logic [FEED_W-1:0]        default_feed_r;
  logic [FEED_W-1:0]        feed_floor_r;
  logic signed [POS_W-1:0]  last_x_r;
  logic signed [POS_W-1:0]  last_y_r;
  logic signed [POS_W-1:0]  last_z_r;
  logic [TOT_W-1:0]         cut_r;
  logic [TOT_W-1:0]         rapid_r;
  logic [TOT_W-1:0]         time_r;
  logic signed [POS_W-1:0]  zlo_r;
  logic signed [POS_W-1:0]  zhi_r;
  logic                     sat_r;
  logic                     out_valid_r;

  logic [POS_W-1:0]         mag_r [AXES];
  logic [2*POS_W-1:0]       prod_r;
  logic [SUM_W-1:0]         sum_r;
  logic [ROOT_W-1:0]        root_r;
  logic [REM_W-1:0]         rem_r;
  logic [TOT_W-1:0]         div_q_r;
  logic [FEED_W-1:0]        div_rem_r;
  logic [FEED_W-1:0]        feed_r;
  logic                     is_rapid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic                     out_sat_r;

  logic                     starts_path;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  move_kind_t               move_kind;
  logic [FEED_W-1:0]        feedrate;

  logic                     in_acc;
  logic                     out_load;
  logic                     kind_rapid;
  logic [FEED_W-1:0]        feed_sel;
  logic [POS_W-1:0]         mag_x;
  logic [POS_W-1:0]         mag_y;
  logic [POS_W-1:0]         mag_z;
  logic [SUB_W-1:0]         sub_a;
  logic [SUB_W-1:0]         sub_b;
  logic [SUB_W:0]           sub_diff;
  logic                     sub_ge;
  logic [TOT_W:0]           len_sum;
  logic [TOT_W-1:0]         len_nxt;
  logic [TOT_W:0]           time_sum;
  logic [TOT_W-1:0]         time_nxt;

  assign starts_path = in_tuser[0];
  assign move_kind   = in_tuser[2:1];
  assign pos_x       = in_tdata[31:0];
  assign pos_y       = in_tdata[63:32];
  assign pos_z       = in_tdata[95:64];
  assign feedrate    = in_tdata[119:96];

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  function automatic logic [POS_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                                logic signed [POS_W-1:0] b);
    logic [POS_W:0] d;
    logic [POS_W:0] n;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    n = '0 - d;
    return d[POS_W] ? n[POS_W-1:0] : d[POS_W-1:0];
  endfunction

  always_comb begin
    kind_rapid = (move_kind inside {KIND_RAPID, KIND_RETRACT});
    if (kind_rapid) begin
      feed_sel = rapid_feed_r;
    end else if (feedrate > feed_floor_r) begin
      feed_sel = feedrate;
    end else begin
      feed_sel = default_feed_r;
    end
    if (feed_sel == '0) begin
      feed_sel = FEED_W'(1);
    end
    mag_x = abs_diff(pos_x, last_x_r);
    mag_y = abs_diff(pos_y, last_y_r);
    mag_z = abs_diff(pos_z, last_z_r);
  end

  // Shared subtractor: root trial during S_ROOT, quotient trial otherwise.
  always_comb begin
    if (state_r == S_ROOT) begin
      sub_a = {rem_r, sum_r[SUM_W-1 -: 2]};
      sub_b = {2'b00, root_r, 2'b01};
    end else begin
      sub_a = {{(SUB_W-FEED_W-1){1'b0}}, div_rem_r, div_q_r[TOT_W-1]};
      sub_b = {{(SUB_W-FEED_W){1'b0}}, feed_r};
    end
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge   = !sub_diff[SUB_W];
  end

  always_comb begin
    len_sum  = {1'b0, (is_rapid_r ? rapid_r : cut_r)} +
               {{(TOT_W+1-ROOT_W){1'b0}}, root_r};
    len_nxt  = (len_sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : len_sum[TOT_W-1:0];
    time_sum = {1'b0, time_r} + {1'b0, div_q_r};
    time_nxt = (time_sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : time_sum[TOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cnt_r          <= '0;
      rapid_feed_r   <= RAPID_FEED_RST;
      default_feed_r <= DEFAULT_FEED_RST;
      feed_floor_r   <= FEED_FLOOR_RST;
      last_x_r       <= '0;
      last_y_r       <= '0;
      last_z_r       <= '0;
      cut_r          <= '0;
      rapid_r        <= '0;
      time_r         <= '0;
      zlo_r          <= POS_MAX;
      zhi_r          <= POS_MIN;
      sat_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      out_data_r     <= '0;
      out_sat_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_RAPID_FEED:   rapid_feed_r   <= cfg_data;
          REG_DEFAULT_FEED: default_feed_r <= cfg_data;
          REG_FEED_FLOOR:   feed_floor_r   <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            last_x_r <= pos_x;
            last_y_r <= pos_y;
            last_z_r <= pos_z;
            cnt_r    <= '0;
            if (starts_path) begin
              cut_r   <= '0;
              rapid_r <= '0;
              time_r  <= '0;
              sat_r   <= 1'b0;
              zlo_r   <= pos_z;
              zhi_r   <= pos_z;
              state_r <= S_DONE;
            end else begin
              if (pos_z < zlo_r) begin
                zlo_r <= pos_z;
              end
              if (pos_z > zhi_r) begin
                zhi_r <= pos_z;
              end
              state_r <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          if (cnt_r == CNT_W'(AXES)) begin
            cnt_r   <= '0;
            state_r <= S_ROOT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_ROOT: begin
          if (cnt_r == CNT_W'(ROOT_STEPS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_LEN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_LEN: begin
          if (is_rapid_r) begin
            rapid_r <= len_nxt;
          end else begin
            cut_r <= len_nxt;
          end
          if (len_nxt == FULL_SCALE) begin
            sat_r <= 1'b1;
          end
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_TIME;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_TIME: begin
          time_r <= time_nxt;
          if (time_nxt == FULL_SCALE) begin
            sat_r <= 1'b1;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_data_r <= {zhi_r, zlo_r, time_r, rapid_r, cut_r};
            out_sat_r  <= sat_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mag_r[0]   <= mag_x;
          mag_r[1]   <= mag_y;
          mag_r[2]   <= mag_z;
          feed_r     <= feed_sel;
          is_rapid_r <= kind_rapid;
          sum_r      <= '0;
        end
      end
      S_SQUARE: begin
        if (cnt_r != '0) begin
          sum_r <= sum_r + {2'b00, prod_r};
        end
        if (cnt_r < CNT_W'(AXES)) begin
          prod_r <= mag_r[cnt_r[1:0]] * mag_r[cnt_r[1:0]];
        end
        root_r <= '0;
        rem_r  <= '0;
      end
      S_ROOT: begin
        sum_r <= {sum_r[SUM_W-3:0], 2'b00};
        if (sub_ge) begin
          rem_r  <= sub_diff[REM_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= sub_a[REM_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      S_LEN: begin
        div_q_r   <= {{(TOT_W-ROOT_W-TIME_SH){1'b0}}, root_r, {TIME_SH{1'b0}}};
        div_rem_r <= '0;
      end
      S_DIV: begin
        div_q_r <= {div_q_r[TOT_W-2:0], sub_ge};
        if (sub_ge) begin
          div_rem_r <= sub_diff[FEED_W-1:0];
        end else begin
          div_rem_r <= sub_a[FEED_W-1:0];
        end
      end
      default: ;
    endcase
  end

  `TMS_ASSERT_NXT(a_move_starts_squaring, in_acc && !starts_path,
                  (state_r == S_SQUARE) && (cnt_r == '0), "move did not enter squaring")
  `TMS_ASSERT_IMP(a_root_count, state_r == S_ROOT, cnt_r < CNT_W'(ROOT_STEPS),
                  "root step count overran")
  `TMS_ASSERT_IMP(a_div_rem_bound, state_r == S_DIV, div_rem_r < feed_r,
                  "divide remainder not below divisor")
  `TMS_ASSERT_IMP(a_sat_flag,
                  (cut_r == FULL_SCALE) || (rapid_r == FULL_SCALE) || (time_r == FULL_SCALE),
                  sat_r, "full-scale total without saturation flag")

endmodule
